// ----- src/dmv_pkg.sv -----
// Shared types and constants for the dense matrix-vector multiply block.
// No dependencies; used by the interfaces, the cells, the MAC unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dmv_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int OP_W = 2;
  localparam int POS_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIM_W = 5;
  localparam int ITER_W = 8;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // input opcodes
  localparam logic [OP_W-1:0] OP_LOAD_MATRIX = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_VECTOR = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT = 2'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;
  localparam logic [ITER_W-1:0] ITER_RESET = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic vec_load;
    logic work_init;
    logic work_copy;
    logic work_rot;
    logic res_shift;
  } cell_ctl_t;

  // one multiply-accumulate issue
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } issue_t;

endpackage : dmv_pkg

`default_nettype wire

// ----- src/dmv_if.sv -----
// Handshake channel interfaces: input items, result items and configuration writes.
// Depends on dmv_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dmv_in_if;
  logic                          valid;
  logic                          ready;
  logic [dmv_pkg::OP_W-1:0]      op;
  logic [dmv_pkg::POS_W-1:0]     row;
  logic [dmv_pkg::POS_W-1:0]     column;
  logic signed [dmv_pkg::DATA_W-1:0] value;

  modport source (output valid, output op, output row, output column, output value,
                  input ready);
  modport sink (input valid, input op, input row, input column, input value,
                output ready);
endinterface : dmv_in_if

interface dmv_out_if;
  logic                          valid;
  logic                          ready;
  logic [dmv_pkg::POS_W-1:0]     index;
  logic signed [dmv_pkg::DATA_W-1:0] result_value;
  logic                          last;

  modport source (output valid, output index, output result_value, output last,
                  input ready);
  modport sink (input valid, input index, input result_value, input last,
                output ready);
endinterface : dmv_out_if

interface dmv_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dmv_pkg::CFG_IDX_W-1:0]   index;
  logic [dmv_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface : dmv_cfg_if

`default_nettype wire

// ----- src/dmv_cell.sv -----
// One cell of the vector chain: loaded vector element, working element, result element.
// Depends on dmv_pkg. Neighbor and wrap-around data come from the top level.
`timescale 1ns / 1ps
`default_nettype none

module dmv_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dmv_pkg::cell_ctl_t ctl,
  input  logic               vec_sel,
  input  logic               active,
  input  logic               is_tail,
  input  dmv_pkg::word_t     vec_data,
  input  dmv_pkg::word_t     right_work,
  input  dmv_pkg::word_t     tail_work,
  input  dmv_pkg::word_t     right_res,
  input  dmv_pkg::word_t     tail_res,
  output dmv_pkg::word_t     work,
  output dmv_pkg::word_t     res
);

  dmv_pkg::word_t vec_r;
  dmv_pkg::word_t work_r;
  dmv_pkg::word_t res_r;

  always_ff @(posedge clk) begin
    if (ctl.vec_load && vec_sel) begin
      vec_r <= vec_data;
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.work_init) begin
      work_r <= vec_r;
    end else if (ctl.work_copy) begin
      work_r <= res_r;
    end else if (ctl.work_rot && active) begin
      work_r <= is_tail ? tail_work : right_work;
    end else begin
      work_r <= work_r;
    end
  end

  // results start at zero and move one place toward the head per shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (ctl.res_shift && active) begin
      res_r <= is_tail ? tail_res : right_res;
    end
  end

  assign work = work_r;
  assign res  = res_r;

endmodule : dmv_cell

`default_nettype wire

// ----- src/dmv_mac.sv -----
// Matrix memory plus the multiply-accumulate pipeline (read, multiply, accumulate).
// Depends on dmv_pkg. Row sums leave saturated to 32 bits on the last column.
`timescale 1ns / 1ps
`default_nettype none

module dmv_mac #(
  parameter int MAX_DIMENSION = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  dmv_pkg::issue_t                                issue,
  input  dmv_pkg::word_t                                 x,
  input  logic [$clog2(MAX_DIMENSION*MAX_DIMENSION)-1:0] raddr,
  input  logic                                           mem_we,
  input  logic [$clog2(MAX_DIMENSION*MAX_DIMENSION)-1:0] waddr,
  input  dmv_pkg::word_t                                 wdata,
  output logic                                           y_valid,
  output dmv_pkg::word_t                                 y,
  output logic                                           busy
);

  localparam int DEPTH = MAX_DIMENSION * MAX_DIMENSION;
  localparam int PROD_W = 2 * dmv_pkg::DATA_W;
  localparam int SH_W = PROD_W - dmv_pkg::FRAC_W;
  localparam int ACC_W = SH_W + $clog2(MAX_DIMENSION) + 1;

  dmv_pkg::word_t mem [DEPTH];

  dmv_pkg::issue_t iss1_r, iss2_r, iss3_r;
  dmv_pkg::word_t  a1_r, x1_r;
  logic signed [PROD_W-1:0] prod2_r;
  logic signed [ACC_W-1:0]  acc3_r;
  logic signed [SH_W-1:0]   prod_sh;
  logic [ACC_W-dmv_pkg::DATA_W:0] acc_hi;
  logic fits;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    a1_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss1_r <= '0;
      iss2_r <= '0;
      iss3_r <= '0;
    end else begin
      iss1_r <= issue;
      iss2_r <= iss1_r;
      iss3_r <= iss2_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= x;
    prod2_r <= a1_r * x1_r;
  end

  // dropping the low fraction bits rounds toward minus infinity
  assign prod_sh = prod2_r[PROD_W-1:dmv_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (iss2_r.valid) begin
      acc3_r <= (iss2_r.first ? '0 : acc3_r) + ACC_W'(prod_sh);
    end
  end

  assign acc_hi = acc3_r[ACC_W-1:dmv_pkg::DATA_W-1];
  assign fits   = (&acc_hi) || !(|acc_hi);

  assign y_valid = iss3_r.valid && iss3_r.last;
  assign y       = fits ? acc3_r[dmv_pkg::DATA_W-1:0]
                        : (acc3_r[ACC_W-1] ? dmv_pkg::WORD_MIN : dmv_pkg::WORD_MAX);
  assign busy    = iss1_r.valid || iss2_r.valid || iss3_r.valid;

endmodule : dmv_mac

`default_nettype wire

// ----- src/dense_matrix_vector_multiply.sv -----
// Dense matrix-vector multiply, signed Q16.16. Load items (matrix or vector element)
// are accepted back to back. A start item computes y = A*x over the configured
// dimension n, feeds y back as x and repeats iteration_count times, then returns the
// n elements of y, the final one marked last. The vector and result sit in a chain
// of cells that rotates one place per cycle past a single multiply-accumulate unit;
// each pass ends by letting the read, multiply and accumulate pipeline drain. Results
// then leave one per cycle while the receiver is ready. Inputs are not accepted while
// a start is in progress.
// Depends on dmv_pkg, dmv_if, dmv_cell and dmv_mac.
`timescale 1ns / 1ps
`default_nettype none

module dense_matrix_vector_multiply #(
  parameter int MAX_DIMENSION = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dmv_in_if.sink    in_ch,
  dmv_out_if.source out_ch,
  dmv_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = $clog2(MAX_DIMENSION);
  localparam int MAW = $clog2(MAX_DIMENSION * MAX_DIMENSION);
  localparam int AW = (IDX_W + 1 > dmv_pkg::POS_W) ? IDX_W + 1 : dmv_pkg::POS_W;
  localparam int CW = (IDX_W + 1 > dmv_pkg::DIM_W) ? IDX_W + 1 : dmv_pkg::DIM_W;

  dmv_pkg::state_t state_r, state_nxt;

  logic [dmv_pkg::DIM_W-1:0]  dim_r;
  logic [dmv_pkg::ITER_W-1:0] iter_cfg_r;
  logic [dmv_pkg::ITER_W-1:0] iter_r;
  logic [IDX_W-1:0] nm1_r, nm1_cfg;
  logic [IDX_W-1:0] col_r, row_r, emit_cnt_r;
  logic [MAW-1:0]   base_r;

  logic in_acc, in_rdy, start_go, calc_step, drain_done, out_load;
  logic row_ok, col_ok, mem_we, vec_load;
  logic [AW-1:0] row_ext, col_ext;
  logic [IDX_W-1:0] row_idx, col_idx;
  logic [CW-1:0] dim_ext;

  dmv_pkg::cell_ctl_t cell_ctl;
  dmv_pkg::issue_t    issue;
  dmv_pkg::word_t     work_w [MAX_DIMENSION];
  dmv_pkg::word_t     res_w  [MAX_DIMENSION];
  dmv_pkg::word_t     tail_res;
  dmv_pkg::word_t     y;
  logic               y_valid, mac_busy;

  logic                          out_valid_r;
  logic [dmv_pkg::POS_W-1:0]     out_index_r;
  dmv_pkg::word_t                out_value_r;
  logic                          out_last_r;

  // ---------------------------------------------------------------- input decode
  assign in_acc  = in_ch.valid && in_rdy;
  assign row_ext = AW'(in_ch.row);
  assign col_ext = AW'(in_ch.column);
  assign row_ok  = row_ext < AW'(MAX_DIMENSION);
  assign col_ok  = col_ext < AW'(MAX_DIMENSION);
  assign row_idx = row_ext[IDX_W-1:0];
  assign col_idx = col_ext[IDX_W-1:0];
  assign mem_we  = in_acc && (in_ch.op == dmv_pkg::OP_LOAD_MATRIX) && row_ok && col_ok;
  assign vec_load = in_acc && (in_ch.op == dmv_pkg::OP_LOAD_VECTOR) && row_ok;

  // effective dimension minus one
  assign dim_ext = CW'(dim_r);
  always_comb begin
    priority if (dim_ext == '0) begin
      nm1_cfg = '0;
    end else if (dim_ext > CW'(MAX_DIMENSION)) begin
      nm1_cfg = IDX_W'(MAX_DIMENSION - 1);
    end else begin
      nm1_cfg = IDX_W'(dim_ext - CW'(1));
    end
  end

  // ---------------------------------------------------------------- configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r      <= dmv_pkg::DIM_RESET;
      iter_cfg_r <= dmv_pkg::ITER_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dmv_pkg::REG_DIMENSION:       dim_r <= cfg_ch.data[dmv_pkg::DIM_W-1:0];
        dmv_pkg::REG_ITERATION_COUNT: iter_cfg_r <= cfg_ch.data[dmv_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control FSM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dmv_pkg::ST_IDLE: begin
        if (in_acc && (in_ch.op == dmv_pkg::OP_START)) begin
          state_nxt = (iter_cfg_r == '0) ? dmv_pkg::ST_EMIT : dmv_pkg::ST_CALC;
        end
      end
      dmv_pkg::ST_CALC: begin
        if ((col_r == nm1_r) && (row_r == nm1_r)) begin
          state_nxt = dmv_pkg::ST_DRAIN;
        end
      end
      dmv_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = (iter_r > dmv_pkg::ITER_W'(1)) ? dmv_pkg::ST_CALC : dmv_pkg::ST_EMIT;
        end
      end
      dmv_pkg::ST_EMIT: begin
        if ((!out_valid_r || out_ch.ready) && (emit_cnt_r == nm1_r)) begin
          state_nxt = dmv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dmv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy     = 1'b0;
    start_go   = 1'b0;
    calc_step  = 1'b0;
    drain_done = 1'b0;
    out_load   = 1'b0;
    cell_ctl   = '0;
    unique case (state_r)
      dmv_pkg::ST_IDLE: begin
        in_rdy   = 1'b1;
        start_go = in_ch.valid && (in_ch.op == dmv_pkg::OP_START);
        cell_ctl.work_init = start_go;
      end
      dmv_pkg::ST_CALC: begin
        calc_step = 1'b1;
        cell_ctl.work_rot = 1'b1;
      end
      dmv_pkg::ST_DRAIN: begin
        drain_done = !mac_busy;
        cell_ctl.work_copy = drain_done && (iter_r > dmv_pkg::ITER_W'(1));
      end
      dmv_pkg::ST_EMIT: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: ;
    endcase
    cell_ctl.vec_load  = vec_load;
    // results shift in from the MAC, or rotate while being emitted
    cell_ctl.res_shift = y_valid || out_load;
  end

  // ---------------------------------------------------------------- counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm1_r      <= '0;
      iter_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
      base_r     <= '0;
      emit_cnt_r <= '0;
    end else begin
      if (start_go) begin
        nm1_r      <= nm1_cfg;
        iter_r     <= iter_cfg_r;
        col_r      <= '0;
        row_r      <= '0;
        base_r     <= '0;
        emit_cnt_r <= '0;
      end
      if (calc_step) begin
        if (col_r == nm1_r) begin
          col_r  <= '0;
          row_r  <= row_r + IDX_W'(1);
          base_r <= base_r + MAW'(MAX_DIMENSION);
        end else begin
          col_r <= col_r + IDX_W'(1);
        end
      end
      if (drain_done) begin
        col_r  <= '0;
        row_r  <= '0;
        base_r <= '0;
        iter_r <= iter_r - dmv_pkg::ITER_W'(1);
      end
      if (out_load) begin
        emit_cnt_r <= (emit_cnt_r == nm1_r) ? '0 : emit_cnt_r + IDX_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- cell chain
  assign tail_res = y_valid ? y : res_w[0];

  for (genvar k = 0; k < MAX_DIMENSION; k++) begin : g_cell
    dmv_pkg::word_t right_work, right_res;

    if (k < MAX_DIMENSION - 1) begin : g_mid
      assign right_work = work_w[k+1];
      assign right_res  = res_w[k+1];
    end else begin : g_end
      assign right_work = work_w[0];
      assign right_res  = tail_res;
    end

    dmv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .vec_sel    (row_idx == IDX_W'(k)),
      .active     (IDX_W'(k) <= nm1_r),
      .is_tail    (IDX_W'(k) == nm1_r),
      .vec_data   (in_ch.value),
      .right_work (right_work),
      .tail_work  (work_w[0]),
      .right_res  (right_res),
      .tail_res   (tail_res),
      .work       (work_w[k]),
      .res        (res_w[k])
    );
  end

  // ---------------------------------------------------------------- MAC unit
  assign issue.valid = calc_step;
  assign issue.first = (col_r == '0);
  assign issue.last  = (col_r == nm1_r);

  dmv_mac #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   (issue),
    .x       (work_w[0]),
    .raddr   (base_r + MAW'(col_r)),
    .mem_we  (mem_we),
    .waddr   (MAW'(row_idx) * MAW'(MAX_DIMENSION) + MAW'(col_idx)),
    .wdata   (in_ch.value),
    .y_valid (y_valid),
    .y       (y),
    .busy    (mac_busy)
  );

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= dmv_pkg::POS_W'(emit_cnt_r);
      out_value_r <= res_w[0];
      out_last_r  <= (emit_cnt_r == nm1_r);
    end
  end

  assign in_ch.ready         = in_rdy;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.index        = out_index_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.last         = out_last_r;

  // ---------------------------------------------------------------- assertions
  a_mac_idle_outside_calc : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dmv_pkg::ST_IDLE || state_r == dmv_pkg::ST_EMIT) |-> !mac_busy)
    else $error("MAC pipeline still busy outside compute");

  a_row_sum_in_calc : assert property (@(posedge clk) disable iff (!rst_n)
    y_valid |-> (state_r == dmv_pkg::ST_CALC || state_r == dmv_pkg::ST_DRAIN))
    else $error("row sum produced outside compute");

  a_emit_ends_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && emit_cnt_r == nm1_r) |=> (state_r == dmv_pkg::ST_IDLE && out_ch.last))
    else $error("emit run did not end on the last element");

  a_no_input_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dmv_pkg::ST_CALC || state_r == dmv_pkg::ST_DRAIN) |-> !in_acc && !out_load)
    else $error("transfer during compute");

endmodule : dense_matrix_vector_multiply

`default_nettype wire
